// ===== hw/rtl/rgb_box_blur_stream_defines.svh =====
// assertion macros for the box blur stream checker
// no dependencies; included by the checker file
`ifndef RGB_BOX_BLUR_STREAM_DEFINES_SVH
`define RGB_BOX_BLUR_STREAM_DEFINES_SVH

// clocked on clk_i, quiet while rst_ni is low
`define RBS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// explicit clock and reset
`define RBS_ASSERT_CR(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

// ===== hw/rtl/rbs_pkg.sv =====
// constants and types of the box blur stream
// no dependencies
package rbs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int RAD_W      = 4;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int QUOT_W     = 8;
  localparam int NCH        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_idx_e;

  typedef logic [NCH-1:0][PIX_W-1:0] rgb_t;

endpackage

// ===== hw/rtl/rbs_stream_if.sv =====
// request channels of the box blur stream: pixel in, blurred pixel out
// depends on rbs_pkg
interface rbs_pix_if;
  logic                    valid;
  logic                    ready;
  logic [rbs_pkg::PIX_W-1:0] pixel_red;
  logic [rbs_pkg::PIX_W-1:0] pixel_green;
  logic [rbs_pkg::PIX_W-1:0] pixel_blue;
  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface rbs_res_if;
  logic                      valid;
  logic                      ready;
  logic [rbs_pkg::PIX_W-1:0] out_red;
  logic [rbs_pkg::PIX_W-1:0] out_green;
  logic [rbs_pkg::PIX_W-1:0] out_blue;
  logic [rbs_pkg::COL_W-1:0] out_col;
  logic [rbs_pkg::ROW_W-1:0] out_row;
  modport source (output valid, out_red, out_green, out_blue, out_col, out_row,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_col, out_row,
                output ready);
endinterface

// ===== hw/rtl/rbs_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module rbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/rgb_box_blur_stream.sv =====
// box blur over a raster rgb stream, line store and column sums in rams
// a request passes ram read, column sum write, window sum and, when a
// result is due, 8 restoring divide steps by the window area and output load
// new pixels wait until the last one is through; output load waits on a stall
// reset (async, active low) clears counters, window sums and config to 640x480, r=3
// depends on rbs_pkg, rbs_stream_if, rbs_ram
module rgb_box_blur_stream #(
  parameter int MAX_RADIUS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rbs_pkg::CFG_W-1:0]       cfg_data_i,
  rbs_pix_if.sink                         pix,
  rbs_res_if.source                       res
);
  localparam int SPAN_MAX = 2 * MAX_RADIUS + 1;
  localparam int RW       = $clog2(MAX_RADIUS + 1);
  localparam int SW       = RW + 1;
  localparam int CSW      = rbs_pkg::PIX_W + SW;
  localparam int WSW      = rbs_pkg::PIX_W + 2 * SW;
  localparam int LS_DEPTH = SPAN_MAX * rbs_pkg::MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int XW       = rbs_pkg::COL_W;
  localparam int YW       = rbs_pkg::ROW_W;
  localparam int NCH      = rbs_pkg::NCH;
  localparam int QW       = rbs_pkg::QUOT_W;
  localparam int STW      = $clog2(QW);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_WIN, S_DIV, S_OUT} state_e;

  state_e state_q;

  logic [rbs_pkg::WIDTH_W-1:0]  width_q;
  logic [rbs_pkg::HEIGHT_W-1:0] height_q;
  logic [rbs_pkg::RAD_W-1:0]    radius_q;

  logic [XW-1:0]    x_q, xi_q;
  logic [YW-1:0]    y_q, yi_q;
  logic [SW-1:0]    slot_q;
  logic [LS_AW-1:0] base_q, addr_q;
  rbs_pkg::rgb_t    pix_q;
  logic [NCH-1:0][CSW-1:0] newcs_q;
  logic [NCH-1:0][WSW-1:0] ws_q, rem_q;
  logic [NCH-1:0][QW-1:0]  quot_q;
  logic [STW-1:0]   step_q;

  logic             out_valid_q;
  rbs_pkg::rgb_t    out_rgb_q;
  logic [XW-1:0]    out_col_q;
  logic [YW-1:0]    out_row_q;

  // effective configuration
  logic [rbs_pkg::WIDTH_W:0] eff_w;
  logic [rbs_pkg::HEIGHT_W-1:0] eff_h;
  logic [RW-1:0]    r_eff;
  logic [SW-1:0]    span, twor;
  logic [2*SW-1:0]  area;

  always_comb begin
    if (width_q == '0) begin
      eff_w = (rbs_pkg::WIDTH_W+1)'(1);
    end else if ({1'b0, width_q} > (rbs_pkg::WIDTH_W+1)'(rbs_pkg::MAX_WIDTH)) begin
      eff_w = (rbs_pkg::WIDTH_W+1)'(rbs_pkg::MAX_WIDTH);
    end else begin
      eff_w = {1'b0, width_q};
    end
    if (height_q == '0) begin
      eff_h = rbs_pkg::HEIGHT_W'(1);
    end else if (height_q > rbs_pkg::HEIGHT_W'(rbs_pkg::MAX_HEIGHT)) begin
      eff_h = rbs_pkg::HEIGHT_W'(rbs_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_q;
    end
    if (radius_q == '0) begin
      r_eff = RW'(1);
    end else if (6'(radius_q) > 6'(MAX_RADIUS)) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(radius_q);
    end
    span = {r_eff, 1'b1};
    twor = {r_eff, 1'b0};
    area = (2*SW)'(span) * (2*SW)'(span);
  end

  // memories
  logic                   ls_we, cs_we;
  logic [LS_AW-1:0]       ls_raddr;
  logic [NCH*rbs_pkg::PIX_W-1:0] ls_rdata;
  logic [XW-1:0]          cs_raddr;
  logic [NCH*CSW-1:0]     cs_rdata;
  logic [NCH-1:0][CSW-1:0] cs_new;
  logic [NCH-1:0][WSW-1:0] ws_new, rem_next;
  logic [NCH-1:0]          qbit;
  logic                    x_ge_span, y_ge_span, emit;
  logic [XW-1:0]           span_x;

  assign span_x    = XW'(span);
  assign x_ge_span = xi_q >= span_x;
  assign y_ge_span = yi_q >= YW'(span);
  assign emit      = (xi_q >= XW'(twor)) && (yi_q >= YW'(twor));

  assign ls_we    = (state_q == S_RD);
  assign cs_we    = (state_q == S_RD);
  assign ls_raddr = base_q + LS_AW'(x_q);
  assign cs_raddr = (state_q == S_IDLE) ? x_q : (xi_q - span_x);

  rbs_ram #(.WIDTH(NCH*rbs_pkg::PIX_W), .DEPTH(LS_DEPTH)) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (addr_q),
    .wdata_i (pix_q),
    .raddr_i (ls_raddr),
    .rdata_o (ls_rdata)
  );

  rbs_ram #(.WIDTH(NCH*CSW), .DEPTH(rbs_pkg::MAX_WIDTH)) u_col_sums (
    .clk_i   (clk_i),
    .we_i    (cs_we),
    .waddr_i (xi_q),
    .wdata_i (cs_new),
    .raddr_i (cs_raddr),
    .rdata_o (cs_rdata)
  );

  always_comb begin
    logic [CSW-1:0] old_cs, leave, prev_cs;
    logic [WSW-1:0] trial, ws_base;
    for (int c = 0; c < NCH; c++) begin
      old_cs  = (yi_q == '0) ? '0 : cs_rdata[c*CSW +: CSW];
      leave   = y_ge_span ? CSW'(ls_rdata[c*rbs_pkg::PIX_W +: rbs_pkg::PIX_W]) : '0;
      cs_new[c] = old_cs + CSW'(pix_q[c]) - leave;
      prev_cs = x_ge_span ? cs_rdata[c*CSW +: CSW] : '0;
      ws_base = (xi_q == '0) ? '0 : ws_q[c];
      ws_new[c] = ws_base + WSW'(newcs_q[c]) - WSW'(prev_cs);
      trial   = WSW'(area) << step_q;
      qbit[c] = rem_q[c] >= trial;
      rem_next[c] = qbit[c] ? (rem_q[c] - trial) : rem_q[c];
    end
  end

  assign pix.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= rbs_pkg::WIDTH_W'(640);
      height_q    <= rbs_pkg::HEIGHT_W'(480);
      radius_q    <= rbs_pkg::RAD_W'(3);
      x_q         <= '0;
      y_q         <= '0;
      slot_q      <= '0;
      base_q      <= '0;
      ws_q        <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (res.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rbs_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[rbs_pkg::WIDTH_W-1:0];
          rbs_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          rbs_pkg::CFG_RADIUS: radius_q <= cfg_data_i[rbs_pkg::RAD_W-1:0];
          default: ;
        endcase
        if (cfg_idx_i <= rbs_pkg::CFG_RADIUS) begin
          x_q    <= '0;
          y_q    <= '0;
          slot_q <= '0;
          base_q <= '0;
          ws_q   <= '0;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (pix.valid) begin
            xi_q   <= x_q;
            yi_q   <= y_q;
            addr_q <= ls_raddr;
            pix_q  <= {pix.pixel_blue, pix.pixel_green, pix.pixel_red};
            if ((12'(x_q) + 12'd1) >= eff_w) begin
              x_q <= '0;
              if ((rbs_pkg::HEIGHT_W'(y_q) + rbs_pkg::HEIGHT_W'(1)) >= eff_h) begin
                y_q    <= '0;
                slot_q <= '0;
                base_q <= '0;
              end else begin
                y_q <= y_q + YW'(1);
                if (slot_q == span - SW'(1)) begin
                  slot_q <= '0;
                  base_q <= '0;
                end else begin
                  slot_q <= slot_q + SW'(1);
                  base_q <= base_q + LS_AW'(rbs_pkg::MAX_WIDTH);
                end
              end
            end else begin
              x_q <= x_q + XW'(1);
            end
            state_q <= S_RD;
          end
        end
        S_RD: begin
          newcs_q <= cs_new;
          state_q <= S_WIN;
        end
        S_WIN: begin
          ws_q   <= ws_new;
          rem_q  <= ws_new;
          quot_q <= '0;
          step_q <= STW'(QW - 1);
          state_q <= emit ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          rem_q <= rem_next;
          for (int c = 0; c < NCH; c++) begin
            quot_q[c] <= {quot_q[c][QW-2:0], qbit[c]};
          end
          step_q <= step_q - STW'(1);
          if (step_q == '0) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || res.ready) begin
            out_valid_q <= 1'b1;
            out_rgb_q   <= quot_q;
            out_col_q   <= xi_q - XW'(r_eff);
            out_row_q   <= yi_q - YW'(r_eff);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res.valid     = out_valid_q;
  assign res.out_red   = out_rgb_q[0];
  assign res.out_green = out_rgb_q[1];
  assign res.out_blue  = out_rgb_q[2];
  assign res.out_col   = out_col_q;
  assign res.out_row   = out_row_q;
endmodule

// ===== hw/rtl/rbs_checker.sv =====
// port-level assertions for rgb_box_blur_stream, bound to the top level
// depends on rgb_box_blur_stream_defines.svh and rbs_pkg
`include "rgb_box_blur_stream_defines.svh"

module rbs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      pix_valid,
  input logic                      pix_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [rbs_pkg::PIX_W-1:0] res_red,
  input logic [rbs_pkg::COL_W-1:0] res_col,
  input logic [rbs_pkg::ROW_W-1:0] res_row
);
  // stalled result holds
  `RBS_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_red) && $stable(res_col) && $stable(res_row), "result changed while stalled")
  // one pixel in flight
  `RBS_ASSERT(a_busy_after_req, pix_valid && pix_ready |=> !pix_ready, "request taken while busy")
  // a new result only comes out of a busy block
  `RBS_ASSERT(a_res_from_work, $rose(res_valid) |-> $past(!pix_ready), "result without work")
endmodule

bind rgb_box_blur_stream rbs_checker u_rbs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_red   (res.out_red),
  .res_col   (res.out_col),
  .res_row   (res.out_row)
);

// ===== tb/rgb_box_blur_stream_tb.sv =====
// self-checking testbench of rgb_box_blur_stream: pixel frames in, centres checked
// depends on rbs_pkg, rbs_stream_if and the rgb_box_blur_stream rtl
module rgb_box_blur_stream_tb;

  localparam int STORE_ROWS = 21;
  localparam int SETTLE     = 40;
  localparam int STALL_LEN  = 400;
  localparam int DOG_LIMIT  = 20000;

  typedef enum logic [1:0] {REQ_PIXEL, REQ_CFG, REQ_DRAIN} req_kind_e;

  typedef struct {
    req_kind_e                   kind;
    logic [rbs_pkg::PIX_W-1:0]   red, green, blue;
    rbs_pkg::cfg_idx_e           idx;
    logic [rbs_pkg::CFG_W-1:0]   data;
  } pix_req_t;

  typedef struct {
    logic [rbs_pkg::PIX_W-1:0] red, green, blue;
    logic [rbs_pkg::COL_W-1:0] col;
    logic [rbs_pkg::ROW_W-1:0] row;
  } blur_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [rbs_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [rbs_pkg::CFG_W-1:0] cfg_data_i;

  rbs_pix_if pix_ch ();
  rbs_res_if res_ch ();

  rgb_box_blur_stream dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix        (pix_ch),
    .res        (res_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 0;
  end

  pix_req_t  req_q[$];
  blur_res_t blur_q[$];
  pix_req_t  q_cur;
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int quiet = 0;
  bit stim_done = 0;

  // blur predictor state
  int unsigned img_w = 640;
  int unsigned img_h = 480;
  int unsigned img_r = 3;
  int unsigned col_cnt, row_cnt;
  int unsigned row_store[STORE_ROWS*rbs_pkg::MAX_WIDTH][rbs_pkg::NCH];
  int unsigned col_sum[rbs_pkg::MAX_WIDTH][rbs_pkg::NCH];
  longint unsigned win_sum[rbs_pkg::NCH];

  function automatic void frame_restart();
    for (int i = 0; i < rbs_pkg::MAX_WIDTH; i++) begin
      for (int c = 0; c < rbs_pkg::NCH; c++) col_sum[i][c] = 0;
    end
    for (int c = 0; c < rbs_pkg::NCH; c++) win_sum[c] = 0;
    col_cnt = 0;
    row_cnt = 0;
  endfunction

  function automatic void blur_cfg(rbs_pkg::cfg_idx_e idx, logic [rbs_pkg::CFG_W-1:0] val);
    case (idx)
      rbs_pkg::CFG_WIDTH: img_w = 32'(val[rbs_pkg::WIDTH_W-1:0]);
      rbs_pkg::CFG_HEIGHT: img_h = 32'(val[rbs_pkg::HEIGHT_W-1:0]);
      rbs_pkg::CFG_RADIUS: img_r = 32'(val[rbs_pkg::RAD_W-1:0]);
      default: return;
    endcase
    frame_restart();
  endfunction

  function automatic void blur_pixel(pix_req_t p);
    int unsigned w, h, r, span, x, y, adr, leaving;
    int unsigned pv[rbs_pkg::NCH];
    longint unsigned area;
    blur_res_t e;
    w = (img_w == 0) ? 1 : (img_w > rbs_pkg::MAX_WIDTH ? rbs_pkg::MAX_WIDTH : img_w);
    h = (img_h == 0) ? 1 : (img_h > rbs_pkg::MAX_HEIGHT ? rbs_pkg::MAX_HEIGHT : img_h);
    r = (img_r == 0) ? 1 : (img_r > 10 ? 10 : img_r);
    span = 2 * r + 1;
    x = (col_cnt >= w) ? w - 1 : col_cnt;
    y = (row_cnt >= h) ? h - 1 : row_cnt;
    if (x == 0 && y == 0) frame_restart();
    pv[0] = 32'(p.red);
    pv[1] = 32'(p.green);
    pv[2] = 32'(p.blue);
    adr = (y % span) * rbs_pkg::MAX_WIDTH + x;
    for (int c = 0; c < rbs_pkg::NCH; c++) begin
      leaving = (y >= span) ? row_store[adr][c] : 0;
      col_sum[x][c] = col_sum[x][c] + pv[c] - leaving;
      row_store[adr][c] = pv[c];
      if (x == 0) win_sum[c] = 0;
      win_sum[c] += col_sum[x][c];
      if (x >= span) win_sum[c] -= col_sum[x-span][c];
    end
    if (x >= 2 * r && y >= 2 * r) begin
      area = 64'(span * span);
      e.red = rbs_pkg::PIX_W'(win_sum[0] / area);
      e.green = rbs_pkg::PIX_W'(win_sum[1] / area);
      e.blue = rbs_pkg::PIX_W'(win_sum[2] / area);
      e.col = rbs_pkg::COL_W'(x - r);
      e.row = rbs_pkg::ROW_W'(y - r);
      blur_q.push_back(e);
    end
    if (x + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
      row_cnt = y;
    end
  endfunction

  task automatic add_cfg(rbs_pkg::cfg_idx_e idx, int val);
    pix_req_t q;
    q.kind = REQ_DRAIN;
    q.red = '0;
    q.green = '0;
    q.blue = '0;
    q.idx = rbs_pkg::CFG_WIDTH;
    q.data = '0;
    req_q.push_back(q);
    q.kind = REQ_CFG;
    q.idx = idx;
    q.data = rbs_pkg::CFG_W'(val);
    req_q.push_back(q);
  endtask

  task automatic add_pixels(int n, int mode);
    pix_req_t q;
    q.kind = REQ_PIXEL;
    q.red = '0;
    q.green = '0;
    q.blue = '0;
    q.idx = rbs_pkg::CFG_WIDTH;
    q.data = '0;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: begin
          q.red = rbs_pkg::PIX_W'($urandom);
          q.green = rbs_pkg::PIX_W'($urandom);
          q.blue = rbs_pkg::PIX_W'($urandom);
        end
        1: {q.red, q.green, q.blue} = '1;
        2: {q.red, q.green, q.blue} = '0;
        default: begin
          q.red = $urandom_range(1) ? 8'hff : 8'h00;
          q.green = $urandom_range(1) ? 8'hff : 8'h00;
          q.blue = $urandom_range(1) ? 8'hff : 8'h00;
        end
      endcase
      req_q.push_back(q);
    end
  endtask

  task automatic add_frame(int w, int h, int r, int frames, int mode);
    add_cfg(rbs_pkg::CFG_WIDTH, w);
    add_cfg(rbs_pkg::CFG_HEIGHT, h);
    add_cfg(rbs_pkg::CFG_RADIUS, r);
    add_pixels(w * h * frames, mode);
  endtask

  function automatic int n_planned();
    int n;
    n = 0;
    foreach (req_q[i]) if (req_q[i].kind == REQ_PIXEL) n++;
    return n;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    pix_req_t q;
    bit nxt_valid, nxt_we;
    if (!rst_ni) begin
      pix_ch.valid <= 1'b0;
      pix_ch.pixel_red <= '0;
      pix_ch.pixel_green <= '0;
      pix_ch.pixel_blue <= '0;
      cfg_we_i <= 1'b0;
      cfg_idx_i <= rbs_pkg::CFG_WIDTH;
      cfg_data_i <= '0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        blur_pixel(q_cur);
        n_sent++;
      end
      nxt_we = 0;
      if (!(pix_ch.valid && !pix_ch.ready)) begin
        nxt_valid = 0;
        if (req_q.size() > 0) begin
          q = req_q[0];
          case (q.kind)
            REQ_PIXEL: begin
              if ((n_sent >= 600 && n_sent < 900) || $urandom_range(99) >= 34) begin
                void'(req_q.pop_front());
                q_cur = q;
                pix_ch.pixel_red <= q.red;
                pix_ch.pixel_green <= q.green;
                pix_ch.pixel_blue <= q.blue;
                nxt_valid = 1;
              end
            end
            REQ_CFG: begin
              if (quiet >= SETTLE) begin
                void'(req_q.pop_front());
                blur_cfg(q.idx, q.data);
                cfg_idx_i <= q.idx;
                cfg_data_i <= q.data;
                nxt_we = 1;
              end
            end
            default: begin
              if (quiet >= SETTLE) void'(req_q.pop_front());
            end
          endcase
        end
        pix_ch.valid <= nxt_valid;
      end
      cfg_we_i <= nxt_we;
    end
  end

  always @(posedge clk_i) begin
    if (blur_q.size() == 0 && !pix_ch.valid && !cfg_we_i) quiet <= quiet + 1;
    else quiet <= 0;
  end

  // result monitor and receiver stalls
  int hold = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    blur_res_t e;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        n_got++;
        if (n_got == 50) hold = STALL_LEN;
        if (blur_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result expected none actual %h %h %h col %0d row %0d",
                   $time, res_ch.out_red, res_ch.out_green, res_ch.out_blue,
                   res_ch.out_col, res_ch.out_row);
        end else begin
          e = blur_q.pop_front();
          if (res_ch.out_red !== e.red || res_ch.out_green !== e.green ||
              res_ch.out_blue !== e.blue || res_ch.out_col !== e.col ||
              res_ch.out_row !== e.row) begin
            errors++;
            $display("%0t: mismatch expected %h %h %h col %0d row %0d",
                     $time, e.red, e.green, e.blue, e.col, e.row);
            $display("%0t: mismatch actual %h %h %h col %0d row %0d",
                     $time, res_ch.out_red, res_ch.out_green, res_ch.out_blue,
                     res_ch.out_col, res_ch.out_row);
          end
        end
      end
      if (hold > 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= (n_got >= 100 && n_got < 160) || $urandom_range(99) >= 34;
      end
    end
  end

  int dog = 0;
  always @(posedge clk_i) begin
    if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we_i)
      dog <= 0;
    else if (!stim_done) dog <= dog + 1;
    if (dog >= DOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int w, h;
    // reset geometry, a few pixels only
    add_pixels(6, 0);
    // smallest window, saturated, dark and black-and-white frames
    add_frame(3, 3, 1, 1, 1);
    add_frame(4, 3, 1, 1, 2);
    add_frame(5, 4, 1, 1, 3);
    // radius zero behaves as one, narrow image gives nothing
    add_frame(4, 4, 0, 1, 0);
    add_frame(2, 5, 1, 1, 0);
    // zero width and zero height
    add_frame(0, 5, 1, 0, 0);
    add_pixels(10, 0);
    add_frame(4, 0, 1, 0, 0);
    add_pixels(12, 0);
    // oversized radius runs as the largest one
    add_frame(22, 21, 15, 1, 3);
    // oversized width, tallest height, partial frames
    add_cfg(rbs_pkg::CFG_WIDTH, 2047);
    add_cfg(rbs_pkg::CFG_HEIGHT, 3);
    add_cfg(rbs_pkg::CFG_RADIUS, 1);
    add_pixels(40, 0);
    add_cfg(rbs_pkg::CFG_WIDTH, 1024);
    add_cfg(rbs_pkg::CFG_HEIGHT, 1);
    add_pixels(40, 0);
    add_frame(4, 8191, 1, 0, 0);
    add_pixels(36, 0);
    add_frame(3, 4096, 2, 0, 0);
    add_pixels(30, 0);

    while (n_planned() < 1250) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 12);
      add_frame(w, h, $urandom_range(0, 3), $urandom_range(1, 3),
                $urandom_range(9) == 0 ? 3 : 0);
      if ($urandom_range(3) == 0) add_pixels($urandom_range(1, w * h), 0);
    end
    add_cfg(rbs_pkg::CFG_RADIUS, 1);

    wait (rst_ni);
    wait (req_q.size() == 0 && blur_q.size() == 0 && quiet >= SETTLE);
    stim_done = 1;
    repeat (50) @(posedge clk_i);
    if (errors == 0 && blur_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

endmodule
